>>> design/cosm_pkg.sv
package cosm_pkg;

  localparam int MAX_CHANNELS = 64;
  localparam int IDX_W        = $clog2(MAX_CHANNELS);
  localparam int CH_W         = 7;
  localparam int ADDR_W       = 16;
  localparam int DUR_W        = 16;
  localparam int RF_W         = 2;
  localparam int LOOKS_W      = $clog2(3 * MAX_CHANNELS + 2);
  localparam int LIM_W        = LOOKS_W + 1;
  localparam int NUM_TIMERS   = 3;
  localparam int QUEUE_DEPTH  = 2;
  localparam int QPTR_W       = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W       = $clog2(QUEUE_DEPTH + 1);
  localparam int CFG_ADDR_W   = 4;
  localparam int IN_DATA_W    = 32;
  localparam int OUT_DATA_W   = 16;

  localparam int T_FIND = 0;
  localparam int T_DATA = 1;
  localparam int T_PROP = 2;

  localparam logic [ADDR_W-1:0] OWN_ADDR_RST = '0;
  localparam logic [CH_W-1:0]   CH_CNT_RST   = CH_W'(MAX_CHANNELS);
  localparam logic [DUR_W-1:0]  SENSE_RST    = DUR_W'(1);
  localparam logic [RF_W-1:0]   RETRY_RST    = RF_W'(3);

  typedef enum logic [1:0] {
    REQ_FRAME = 2'd0,
    REQ_MAC   = 2'd1,
    REQ_TICK  = 2'd2
  } req_type_t;

  typedef enum logic [2:0] {
    FK_RTS      = 3'd0,
    FK_CTS      = 3'd1,
    FK_ACK      = 3'd2,
    FK_RTS_NACK = 3'd3,
    FK_DATA     = 3'd4,
    FK_EOT      = 3'd5,
    FK_PU_START = 3'd6,
    FK_PU_END   = 3'd7
  } frame_kind_t;

  typedef enum logic [1:0] {
    SK_FIND = 2'd0,
    SK_DATA = 2'd1,
    SK_PROP = 2'd2
  } sense_kind_t;

  typedef enum logic [1:0] {
    RK_FREE_SEARCH = 2'd0,
    RK_DATA_CHAN   = 2'd1,
    RK_PROPOSED    = 2'd2,
    RK_PU_NOTICE   = 2'd3
  } reply_kind_t;

  typedef enum logic [2:0] {
    CMD_SET_DC    = 3'd0,
    CMD_MARK_BUSY = 3'd1,
    CMD_MARK_FREE = 3'd2,
    CMD_PU_START  = 3'd3,
    CMD_FIND      = 3'd4,
    CMD_CHK_DATA  = 3'd5,
    CMD_CHK_PROP  = 3'd6,
    CMD_TICK      = 3'd7
  } cmd_kind_t;

  typedef enum logic [1:0] {
    REG_OWN_ADDR  = 2'd0,
    REG_CH_COUNT  = 2'd1,
    REG_SENSE_DUR = 2'd2,
    REG_RETRY     = 2'd3
  } cfg_reg_t;

  typedef enum logic {
    BK_IDLE = 1'b0,
    BK_FIRE = 1'b1
  } bk_state_t;

  typedef struct packed {
    cmd_kind_t       kind;
    logic [CH_W-1:0] ch;
  } cmd_t;

  typedef struct packed {
    logic [ADDR_W-1:0] own_address;
    logic [CH_W-1:0]   channel_count;
    logic [DUR_W-1:0]  sense_duration;
    logic [RF_W-1:0]   retry_factor;
  } cfg_t;

  typedef struct packed {
    reply_kind_t     kind;
    logic            free;
    logic [CH_W-1:0] ch;
    logic            last;
  } reply_t;

  typedef struct packed {
    logic                  firing;
    logic [NUM_TIMERS-1:0] fire_mask;
  } bk_stat_t;

endpackage

>>> design/cosm_front.sv
module cosm_front (
  input  logic                                in_tvalid,
  output logic                                in_tready,
  input  logic [cosm_pkg::IN_DATA_W-1:0]      in_tdata,
  input  logic [cosm_pkg::ADDR_W-1:0]         own_address,
  output logic                                push_valid,
  input  logic                                push_ready,
  output cosm_pkg::cmd_t                      push_data
);
  import cosm_pkg::*;

  logic [1:0]        req;
  logic [ADDR_W-1:0] dest;
  logic [2:0]        fkind;
  logic [1:0]        skind;
  logic [CH_W-1:0]   ch;
  logic              useful;
  cmd_kind_t         kind;

  assign req   = in_tdata[1:0];
  assign dest  = in_tdata[17:2];
  assign fkind = in_tdata[20:18];
  assign skind = in_tdata[22:21];
  assign ch    = in_tdata[29:23];

  // words that change nothing are dropped here
  always_comb begin
    useful = 1'b0;
    kind   = CMD_TICK;
    case (req_type_t'(req))
      REQ_FRAME: begin
        if (dest == own_address) begin
          if (fkind == FK_DATA || fkind == FK_CTS) begin
            useful = 1'b1;
            kind   = CMD_SET_DC;
          end
        end else begin
          case (frame_kind_t'(fkind))
            FK_CTS, FK_ACK, FK_DATA: begin
              useful = 1'b1;
              kind   = CMD_MARK_BUSY;
            end
            FK_EOT, FK_PU_END: begin
              useful = 1'b1;
              kind   = CMD_MARK_FREE;
            end
            FK_PU_START: begin
              useful = 1'b1;
              kind   = CMD_PU_START;
            end
            default: useful = 1'b0;
          endcase
        end
      end
      REQ_MAC: begin
        case (sense_kind_t'(skind))
          SK_FIND: begin
            useful = 1'b1;
            kind   = CMD_FIND;
          end
          SK_DATA: begin
            useful = 1'b1;
            kind   = CMD_CHK_DATA;
          end
          SK_PROP: begin
            useful = 1'b1;
            kind   = CMD_CHK_PROP;
          end
          default: useful = 1'b0;
        endcase
      end
      REQ_TICK: begin
        useful = 1'b1;
        kind   = CMD_TICK;
      end
      default: useful = 1'b0;
    endcase
  end

  assign in_tready      = push_ready;
  assign push_valid     = in_tvalid && useful;
  assign push_data.kind = kind;
  assign push_data.ch   = ch;

endmodule

>>> design/cosm_queue.sv
module cosm_queue (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           push_valid,
  output logic           push_ready,
  input  cosm_pkg::cmd_t push_data,
  output logic           pop_valid,
  input  logic           pop_ready,
  output cosm_pkg::cmd_t pop_data
);
  import cosm_pkg::*;

  cmd_t              mem_r [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [QPTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [QCNT_W-1:0] cnt_r, cnt_nxt;
  logic              do_push, do_pop;

  assign push_ready = (cnt_r != QCNT_W'(QUEUE_DEPTH));
  assign pop_valid  = (cnt_r != '0);
  assign pop_data   = mem_r[rd_ptr_r];
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop_valid && pop_ready;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (do_push && !do_pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (do_pop && !do_push) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= push_data;
    end
  end

endmodule

>>> design/cosm_back.sv
module cosm_back (
  input  logic               clk,
  input  logic               rst_n,
  input  cosm_pkg::cfg_t     cfg,
  input  logic               pop_valid,
  output logic               pop_ready,
  input  cosm_pkg::cmd_t     pop_data,
  output logic               out_tvalid,
  input  logic               out_tready,
  output cosm_pkg::reply_t   out_reply,
  output cosm_pkg::bk_stat_t stat
);
  import cosm_pkg::*;

  bk_state_t             state_r, state_nxt;
  logic [MAX_CHANNELS-1:0] map_r, map_nxt;
  logic [IDX_W-1:0]      scan_r, scan_nxt;
  logic [LOOKS_W-1:0]    looks_r, looks_nxt;
  logic [CH_W-1:0]       dc_r, dc_nxt;
  logic [CH_W-1:0]       pt_r, pt_nxt;
  logic [NUM_TIMERS-1:0] armed_r, armed_nxt;
  logic [DUR_W-1:0]      rem_r [NUM_TIMERS];
  logic [DUR_W-1:0]      rem_nxt [NUM_TIMERS];
  logic [NUM_TIMERS-1:0] fire_r, fire_nxt;
  logic                  out_vld_r, out_vld_nxt;
  reply_t                out_r, out_nxt;

  logic                  slot_free;
  logic [CH_W-1:0]       eff_cnt;
  logic [LIM_W-1:0]      limit;
  logic [DUR_W-1:0]      dur;
  logic [NUM_TIMERS-1:0] fire_now;
  logic [NUM_TIMERS-1:0] fire_sel;
  logic [NUM_TIMERS-1:0] fire_rest;
  logic                  pop_tick;
  logic [CH_W-1:0]       scan_id;
  logic                  scan_busy;
  logic [LOOKS_W-1:0]    looks_inc;
  logic                  emit;
  reply_t                emit_data;

  function automatic logic ch_ok(input logic [CH_W-1:0] id, input logic [CH_W-1:0] cnt);
    return (id != '0) && (id <= cnt);
  endfunction

  function automatic logic [IDX_W-1:0] ch_idx(input logic [CH_W-1:0] id);
    logic [CH_W-1:0] z;
    z = id - 1'b1;
    return IDX_W'(z);
  endfunction

  // out-of-range ids read as busy
  function automatic logic ch_busy(input logic [CH_W-1:0] id, input logic [CH_W-1:0] cnt,
                                   input logic [MAX_CHANNELS-1:0] map);
    return !ch_ok(id, cnt) || map[ch_idx(id)];
  endfunction

  always_comb begin
    if (cfg.channel_count == '0) begin
      eff_cnt = CH_W'(1);
    end else if (cfg.channel_count > CH_W'(MAX_CHANNELS)) begin
      eff_cnt = CH_W'(MAX_CHANNELS);
    end else begin
      eff_cnt = cfg.channel_count;
    end
  end

  assign limit     = LIM_W'(cfg.retry_factor) * LIM_W'(eff_cnt);
  assign dur       = (cfg.sense_duration == '0) ? DUR_W'(1) : cfg.sense_duration;
  assign slot_free = !out_vld_r || out_tready;
  assign scan_id   = CH_W'(scan_r) + 1'b1;
  assign scan_busy = (scan_id > eff_cnt) || map_r[scan_r];
  assign looks_inc = looks_r + 1'b1;

  always_comb begin
    for (int t = 0; t < NUM_TIMERS; t++) begin
      fire_now[t] = armed_r[t] && (rem_r[t] <= DUR_W'(1));
    end
  end

  // expired timers are served in order: find, data, proposed
  always_comb begin
    fire_sel = '0;
    if (fire_r[T_FIND]) begin
      fire_sel[T_FIND] = 1'b1;
    end else if (fire_r[T_DATA]) begin
      fire_sel[T_DATA] = 1'b1;
    end else if (fire_r[T_PROP]) begin
      fire_sel[T_PROP] = 1'b1;
    end
  end

  assign fire_rest = fire_r & ~fire_sel;
  assign pop_tick  = (state_r == BK_IDLE) && pop_valid && slot_free &&
                     (pop_data.kind == CMD_TICK);

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      BK_IDLE: if (pop_tick && (fire_now != '0)) state_nxt = BK_FIRE;
      BK_FIRE: if (slot_free && (fire_rest == '0)) state_nxt = BK_IDLE;
      default: state_nxt = BK_IDLE;
    endcase
  end

  // datapath and outputs
  always_comb begin
    map_nxt   = map_r;
    scan_nxt  = scan_r;
    looks_nxt = looks_r;
    dc_nxt    = dc_r;
    pt_nxt    = pt_r;
    armed_nxt = armed_r;
    rem_nxt   = rem_r;
    fire_nxt  = fire_r;
    pop_ready = 1'b0;
    emit      = 1'b0;
    emit_data = '0;

    case (state_r)
      BK_IDLE: begin
        pop_ready = slot_free;
        if (pop_valid && slot_free) begin
          case (pop_data.kind)
            CMD_SET_DC: dc_nxt = pop_data.ch;
            CMD_MARK_BUSY: begin
              if (ch_ok(pop_data.ch, eff_cnt)) map_nxt[ch_idx(pop_data.ch)] = 1'b1;
            end
            CMD_MARK_FREE: begin
              if (ch_ok(pop_data.ch, eff_cnt)) map_nxt[ch_idx(pop_data.ch)] = 1'b0;
            end
            CMD_PU_START: begin
              if (ch_ok(pop_data.ch, eff_cnt)) begin
                map_nxt[ch_idx(pop_data.ch)] = 1'b1;
                if (pop_data.ch == dc_r) begin
                  dc_nxt         = '0;
                  emit           = 1'b1;
                  emit_data.kind = RK_PU_NOTICE;
                  emit_data.last = 1'b1;
                end
              end
            end
            CMD_FIND: begin
              looks_nxt        = '0;
              armed_nxt[T_FIND] = 1'b1;
              rem_nxt[T_FIND]   = dur;
            end
            CMD_CHK_DATA: begin
              dc_nxt            = pop_data.ch;
              armed_nxt[T_DATA] = 1'b1;
              rem_nxt[T_DATA]   = dur;
            end
            CMD_CHK_PROP: begin
              pt_nxt            = pop_data.ch;
              armed_nxt[T_PROP] = 1'b1;
              rem_nxt[T_PROP]   = dur;
            end
            CMD_TICK: begin
              for (int t = 0; t < NUM_TIMERS; t++) begin
                if (armed_r[t]) begin
                  if (fire_now[t]) begin
                    rem_nxt[t]   = '0;
                    armed_nxt[t] = 1'b0;
                  end else begin
                    rem_nxt[t] = rem_r[t] - 1'b1;
                  end
                end
              end
              fire_nxt = fire_now;
            end
            default: emit = 1'b0;
          endcase
        end
      end
      BK_FIRE: begin
        if (slot_free) begin
          fire_nxt       = fire_rest;
          emit_data.last = (fire_rest == '0);
          if (fire_sel[T_FIND]) begin
            if (scan_busy) begin
              if ({1'b0, looks_inc} > limit) begin
                looks_nxt      = '0;
                emit           = 1'b1;
                emit_data.kind = RK_FREE_SEARCH;
              end else begin
                looks_nxt         = looks_inc;
                scan_nxt          = (scan_id >= eff_cnt) ? '0 : scan_r + 1'b1;
                armed_nxt[T_FIND] = 1'b1;
                rem_nxt[T_FIND]   = dur;
              end
            end else begin
              dc_nxt         = scan_id;
              emit           = 1'b1;
              emit_data.kind = RK_FREE_SEARCH;
              emit_data.free = 1'b1;
              emit_data.ch   = scan_id;
            end
          end else if (fire_sel[T_DATA]) begin
            emit           = 1'b1;
            emit_data.kind = RK_DATA_CHAN;
            if (ch_busy(dc_r, eff_cnt, map_r)) begin
              looks_nxt = '0;
            end else begin
              emit_data.free = 1'b1;
            end
          end else if (fire_sel[T_PROP]) begin
            emit           = 1'b1;
            emit_data.kind = RK_PROPOSED;
            emit_data.free = !ch_busy(pt_r, eff_cnt, map_r);
          end
        end
      end
      default: pop_ready = 1'b0;
    endcase

    out_vld_nxt = emit ? 1'b1 : (out_tready ? 1'b0 : out_vld_r);
    out_nxt     = emit ? emit_data : out_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= BK_IDLE;
      map_r     <= '0;
      scan_r    <= '0;
      looks_r   <= '0;
      dc_r      <= '0;
      pt_r      <= '0;
      armed_r   <= '0;
      fire_r    <= '0;
      out_vld_r <= 1'b0;
      for (int t = 0; t < NUM_TIMERS; t++) begin
        rem_r[t] <= '0;
      end
    end else begin
      state_r   <= state_nxt;
      map_r     <= map_nxt;
      scan_r    <= scan_nxt;
      looks_r   <= looks_nxt;
      dc_r      <= dc_nxt;
      pt_r      <= pt_nxt;
      armed_r   <= armed_nxt;
      fire_r    <= fire_nxt;
      out_vld_r <= out_vld_nxt;
      rem_r     <= rem_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_r <= out_nxt;
  end

  assign out_tvalid     = out_vld_r;
  assign out_reply      = out_r;
  assign stat.firing    = (state_r == BK_FIRE);
  assign stat.fire_mask = fire_r;

endmodule

>>> design/channel_occupancy_sensing_manager.sv
// path: a pu-start notice passes the command queue and then the output register; a
//   tick's results pass the command queue, the expired-timer register and the output
//   register, one result per expired timer, a rescanning free search giving none
// flow: one word per cycle while the command queue has room; a tick with expired
//   timers holds the back end while it serves them one at a time, up to three, while the 2-entry command queue fills
// reset: synchronous active-low rst_n clears all channels to free, disarms all timers
//   and loads the registers with own address 0, 64 channels, duration 1, retry 3
module channel_occupancy_sensing_manager (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 in_tvalid,
  output logic                                 in_tready,
  // req_type[1:0], dest_address[17:2], frame_kind[20:18], sense_kind[22:21],
  // channel_id[29:23], zero[31:30]
  input  logic [cosm_pkg::IN_DATA_W-1:0]       in_tdata,
  output logic                                 out_tvalid,
  input  logic                                 out_tready,
  // reply_kind[1:0], channel_free[2], reply_channel[9:3], zero[15:10]
  output logic [cosm_pkg::OUT_DATA_W-1:0]      out_tdata,
  output logic                                 out_tlast,
  input  logic                                 cfg_psel,
  input  logic                                 cfg_penable,
  input  logic                                 cfg_pwrite,
  input  logic [cosm_pkg::CFG_ADDR_W-1:0]      cfg_paddr,
  input  logic [31:0]                          cfg_pwdata,
  output logic [31:0]                          cfg_prdata,
  output logic                                 cfg_pready
);
  import cosm_pkg::*;

  cfg_t     cfg_r;
  logic     cfg_wr;
  cfg_reg_t cfg_sel;
  logic     q_push_valid, q_push_ready;
  cmd_t     q_push_data;
  logic     q_pop_valid, q_pop_ready;
  cmd_t     q_pop_data;
  reply_t   reply;
  bk_stat_t bk_stat;

  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;
  assign cfg_sel    = cfg_reg_t'(cfg_paddr[3:2]);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.own_address    <= OWN_ADDR_RST;
      cfg_r.channel_count  <= CH_CNT_RST;
      cfg_r.sense_duration <= SENSE_RST;
      cfg_r.retry_factor   <= RETRY_RST;
    end else if (cfg_wr) begin
      case (cfg_sel)
        REG_OWN_ADDR:  cfg_r.own_address    <= cfg_pwdata[ADDR_W-1:0];
        REG_CH_COUNT:  cfg_r.channel_count  <= cfg_pwdata[CH_W-1:0];
        REG_SENSE_DUR: cfg_r.sense_duration <= cfg_pwdata[DUR_W-1:0];
        REG_RETRY:     cfg_r.retry_factor   <= cfg_pwdata[RF_W-1:0];
        default:       cfg_r                <= cfg_r;
      endcase
    end
  end

  always_comb begin
    case (cfg_sel)
      REG_OWN_ADDR:  cfg_prdata = 32'(cfg_r.own_address);
      REG_CH_COUNT:  cfg_prdata = 32'(cfg_r.channel_count);
      REG_SENSE_DUR: cfg_prdata = 32'(cfg_r.sense_duration);
      REG_RETRY:     cfg_prdata = 32'(cfg_r.retry_factor);
      default:       cfg_prdata = '0;
    endcase
  end

  cosm_front u_front (
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .in_tdata    (in_tdata),
    .own_address (cfg_r.own_address),
    .push_valid  (q_push_valid),
    .push_ready  (q_push_ready),
    .push_data   (q_push_data)
  );

  cosm_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (q_push_valid),
    .push_ready (q_push_ready),
    .push_data  (q_push_data),
    .pop_valid  (q_pop_valid),
    .pop_ready  (q_pop_ready),
    .pop_data   (q_pop_data)
  );

  cosm_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg        (cfg_r),
    .pop_valid  (q_pop_valid),
    .pop_ready  (q_pop_ready),
    .pop_data   (q_pop_data),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_reply  (reply),
    .stat       (bk_stat)
  );

  assign out_tdata = {6'b0, reply.ch, reply.free, reply.kind};
  assign out_tlast = reply.last;

  // the back end only serves timers while some are still pending
  a_fire_mask: assert property (@(posedge clk) disable iff (!rst_n)
    bk_stat.firing |-> (bk_stat.fire_mask != '0))
    else $error("firing with no expired timer");

  // no command leaves the queue while timers are being served
  a_no_pop_fire: assert property (@(posedge clk) disable iff (!rst_n)
    bk_stat.firing |-> !q_pop_ready)
    else $error("queue popped during timer service");

  // timer service starts only right after a tick command
  a_fire_after_tick: assert property (@(posedge clk) disable iff (!rst_n)
    (bk_stat.firing && !$past(bk_stat.firing)) |->
      $past(q_pop_valid && q_pop_ready && (q_pop_data.kind == CMD_TICK)))
    else $error("timer service without tick");

endmodule
